### rtl/core/trm_pkg.sv
// Package for the toy register machine: sizes, opcode and status codes,
// beat payload structs and the control bundle passed from trm_exec to the top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trm_pkg;

	// Fixed machine geometry
	localparam int MemDepth     = 256;
	localparam int MemAw        = $clog2(MemDepth);
	localparam int RegCount     = 4;
	localparam int RegAw        = $clog2(RegCount);
	localparam int DataWidthDef = 32;
	localparam int PcW          = 9;
	localparam int OutW         = 32;

	// Memory size limit after reset
	localparam logic [PcW-1:0] CfgReset = PcW'(MemDepth);

	// Command codes
	localparam logic CMD_PRELOAD = 1'b0;
	localparam logic CMD_EXEC    = 1'b1;

	typedef enum logic [3:0] {
		OP_LOAD      = 4'd0,
		OP_STORE     = 4'd1,
		OP_ADD       = 4'd2,
		OP_HALT      = 4'd3,
		OP_JUMP      = 4'd4,
		OP_JUMP_IF   = 4'd5,
		OP_INC       = 4'd6,
		OP_M0_INC    = 4'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_HALTED  = 2'd1,
		ST_RANGE   = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Input beat
	typedef struct packed {
		logic        command;
		logic [3:0]  opcode;
		logic [7:0]  operand_a;
		logic [7:0]  operand_b;
		logic [7:0]  operand_c;
		logic [7:0]  preload_address;
		logic [31:0] preload_value;
	} in_item_t;

	// Output beat
	typedef struct packed {
		logic [1:0]      status;
		logic [PcW-1:0]  program_counter;
		logic [OutW-1:0] written_value;
	} out_item_t;

	// Decoded control for one instruction
	typedef struct packed {
		status_t          status;
		logic [PcW-1:0]   pc_next;
		logic             stop;
		logic             rf_we;
		logic [RegAw-1:0] rf_idx;
		logic             mem_we;
		logic [MemAw-1:0] mem_waddr;
		logic             mem_rd;
		logic [MemAw-1:0] mem_raddr;
	} exec_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/toy_register_machine_step_top.sv
// A beat accepted into s1 passes through s2 and the output register before its result shows on out_valid.
// Throughput: one instruction or preload per cycle; stages hold only while out_stall backs up.
// Stage s1 reads the register file, stage s2 reads data memory; forwarding covers the register reads.
// Reset clears counter, halt flag and register file (valid bits), and sets the size limit to 256.
// Data memory has no reset: words read before being written are undefined.
`timescale 1ns / 1ps
`default_nettype none

module toy_register_machine_step_top import trm_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [PcW-1:0] cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire in_item_t       in_item,
	output logic                out_valid,
	input  wire logic           out_stall,
	output out_item_t           out_item
);

	// Architectural state
	logic [PcW-1:0]        cfg_q;
	logic [PcW-1:0]        pc_q;
	logic                  stopped_q;
	logic [DATA_WIDTH-1:0] m0_q;

	// Memories
	logic [DATA_WIDTH-1:0] rf_mem [RegCount];
	logic [RegCount-1:0]   rf_vld_q;
	logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
	logic                  rd_a_vld_q, rd_b_vld_q;
	logic [RegAw-1:0]      rf_raddr_a, rf_raddr_b;
	logic [DATA_WIDTH-1:0] dmem [MemDepth];
	logic [DATA_WIDTH-1:0] dm_rdata_q;
	logic [MemAw-1:0]      dm_raddr;

	// Pipeline
	logic                  valid_s1;
	in_item_t              item_s1;
	logic                  valid_s2;
	status_t               status_s2;
	logic [PcW-1:0]        pc_s2;
	logic                  rf_we_s2;
	logic [RegAw-1:0]      rf_idx_s2;
	logic                  ld_s2;
	logic [DATA_WIDTH-1:0] res_s2;
	logic [MemAw-1:0]      raddr_s2;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	// Last register write, not yet visible in the read data
	logic                  wb_we_q;
	logic [RegAw-1:0]      wb_idx_q;
	logic [DATA_WIDTH-1:0] wb_data_q;

	logic                  out_ok, s2_adv, s1_adv, load_new;
	logic [DATA_WIDTH-1:0] s2_data, ra_fwd, rb_fwd, ra_raw, rb_raw;
	logic [63:0]           s2_wide;
	logic [RegAw-1:0]      idx_a_s1, idx_b_s1;
	exec_ctrl_t            ctrl;
	logic [DATA_WIDTH-1:0] result;

	// Stage flow control
	assign out_ok    = !out_valid_q || !out_stall;
	assign s2_adv    = valid_s2 && out_ok;
	assign s1_adv    = valid_s1 && (!valid_s2 || s2_adv);
	assign load_new  = !valid_s1 || s1_adv;
	assign in_stall  = !load_new;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Register file: re-read every cycle for the item held in s1
	assign idx_a_s1   = item_s1.operand_a[RegAw-1:0];
	assign idx_b_s1   = item_s1.operand_b[RegAw-1:0];
	assign rf_raddr_a = load_new ? in_item.operand_a[RegAw-1:0] : idx_a_s1;
	assign rf_raddr_b = load_new ? in_item.operand_b[RegAw-1:0] : idx_b_s1;

	always_ff @(posedge clk) begin
		rd_a_q <= rf_mem[rf_raddr_a];
		rd_b_q <= rf_mem[rf_raddr_b];
		if (s2_adv && rf_we_s2) begin
			rf_mem[rf_idx_s2] <= s2_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q   <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
			wb_we_q    <= 1'b0;
		end else begin
			rd_a_vld_q <= rf_vld_q[rf_raddr_a];
			rd_b_vld_q <= rf_vld_q[rf_raddr_b];
			wb_we_q    <= s2_adv && rf_we_s2;
			if (s2_adv && rf_we_s2) begin
				rf_vld_q[rf_idx_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wb_idx_q  <= rf_idx_s2;
		wb_data_q <= s2_data;
	end

	// Forwarding: pending s2 write first, then the write of the last edge
	assign s2_data = ld_s2 ? dm_rdata_q : res_s2;
	assign ra_raw  = rd_a_vld_q ? rd_a_q : '0;
	assign rb_raw  = rd_b_vld_q ? rd_b_q : '0;

	always_comb begin
		ra_fwd = ra_raw;
		if (valid_s2 && rf_we_s2 && rf_idx_s2 == idx_a_s1) begin
			ra_fwd = s2_data;
		end else if (wb_we_q && wb_idx_q == idx_a_s1) begin
			ra_fwd = wb_data_q;
		end
		rb_fwd = rb_raw;
		if (valid_s2 && rf_we_s2 && rf_idx_s2 == idx_b_s1) begin
			rb_fwd = s2_data;
		end else if (wb_we_q && wb_idx_q == idx_b_s1) begin
			rb_fwd = wb_data_q;
		end
	end

	trm_exec #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_exec (
		.item            (item_s1),
		.pc              (pc_q),
		.stopped         (stopped_q),
		.mem_words_in_use(cfg_q),
		.ra              (ra_fwd),
		.rb              (rb_fwd),
		.m0              (m0_q),
		.ctrl            (ctrl),
		.result          (result)
	);

	// Data memory: write and load read at s1 advance, held address otherwise
	assign dm_raddr = s1_adv ? ctrl.mem_raddr : raddr_s2;

	always_ff @(posedge clk) begin
		dm_rdata_q <= dmem[dm_raddr];
		if (s1_adv && ctrl.mem_we) begin
			dmem[ctrl.mem_waddr] <= result;
		end
		// shadow of word zero for the word-zero increment
		if (s1_adv && ctrl.mem_we && ctrl.mem_waddr == '0) begin
			m0_q <= result;
		end
	end

	// Counter and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			stopped_q <= 1'b0;
		end else if (s1_adv) begin
			pc_q      <= ctrl.pc_next;
			stopped_q <= stopped_q || ctrl.stop;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_new) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || s2_adv) begin
				valid_s2 <= s1_adv;
			end
			if (out_ok) begin
				out_valid_q <= s2_adv;
			end
		end
	end

	// Pipeline payload
	assign s2_wide = 64'(s2_data);

	always_ff @(posedge clk) begin
		if (load_new) begin
			item_s1 <= in_item;
		end
		if (s1_adv) begin
			status_s2 <= ctrl.status;
			pc_s2     <= ctrl.pc_next;
			rf_we_s2  <= ctrl.rf_we;
			rf_idx_s2 <= ctrl.rf_idx;
			ld_s2     <= ctrl.mem_rd;
			res_s2    <= result;
			raddr_s2  <= ctrl.mem_raddr;
		end
		if (s2_adv) begin
			out_item_q.status          <= status_s2;
			out_item_q.program_counter <= pc_s2;
			out_item_q.written_value   <= s2_wide[OutW-1:0];
		end
	end

	// Checks
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt flag cleared");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(pc_q))
		else $error("counter moved without an advancing instruction");

	a_halted_status: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && stopped_q) |=> (status_s2 == ST_HALTED && !rf_we_s2))
		else $error("item after halt was not answered as halted");

	a_load_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ld_s2) |-> rf_we_s2)
		else $error("memory load without register write-back");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with free stage");

endmodule

`default_nettype wire

### rtl/core/trm_exec.sv
// Decode and execute for one instruction: range check, next counter,
// register/memory write control and the computed write value.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_exec import trm_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDef
) (
	input  in_item_t              item,
	input  logic [PcW-1:0]        pc,
	input  logic                  stopped,
	input  logic [PcW-1:0]        mem_words_in_use,
	input  logic [DATA_WIDTH-1:0] ra,
	input  logic [DATA_WIDTH-1:0] rb,
	input  logic [DATA_WIDTH-1:0] m0,
	output exec_ctrl_t            ctrl,
	output logic [DATA_WIDTH-1:0] result
);

	always_comb begin
		ctrl           = '0;
		ctrl.status    = ST_DONE;
		ctrl.pc_next   = pc;
		ctrl.rf_idx    = item.operand_a[RegAw-1:0];
		ctrl.mem_waddr = item.operand_a[MemAw-1:0];
		ctrl.mem_raddr = rb[MemAw-1:0];
		result         = '0;

		if (stopped) begin
			ctrl.status = ST_HALTED;
		end else if (item.command == CMD_PRELOAD) begin
			ctrl.mem_we    = 1'b1;
			ctrl.mem_waddr = item.preload_address[MemAw-1:0];
			result         = DATA_WIDTH'(item.preload_value);
		end else if (pc >= mem_words_in_use) begin
			ctrl.status = ST_RANGE;
		end else begin
			ctrl.pc_next = pc + PcW'(1);
			unique case (item.opcode)
				OP_LOAD: begin
					// value arrives from data memory one stage later
					ctrl.rf_we  = 1'b1;
					ctrl.mem_rd = 1'b1;
				end
				OP_STORE: begin
					ctrl.mem_we = 1'b1;
					result      = rb;
				end
				OP_ADD: begin
					ctrl.rf_we  = 1'b1;
					ctrl.rf_idx = item.operand_c[RegAw-1:0];
					result      = ra + rb;
				end
				OP_HALT: begin
					ctrl.stop    = 1'b1;
					ctrl.status  = ST_HALTED;
					ctrl.pc_next = pc;
				end
				OP_JUMP: begin
					ctrl.pc_next = PcW'(item.operand_a);
				end
				OP_JUMP_IF: begin
					ctrl.pc_next = (ra == rb) ? PcW'(item.operand_c) : pc;
				end
				OP_INC: begin
					ctrl.rf_we = 1'b1;
					result     = ra + DATA_WIDTH'(1);
				end
				OP_M0_INC: begin
					ctrl.rf_we = 1'b1;
					result     = m0 + DATA_WIDTH'(1);
				end
				default: begin
					ctrl.status = ST_UNKNOWN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_toy_register_machine_step_top.sv
// Testbench for toy_register_machine_step_top: directed table, then random programs, all checked beat
// by beat against the table's expected beats or an in-bench model of the register machine.
// Depends on trm_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_toy_register_machine_step_top;
	import trm_pkg::*;

	// Opcodes with no meaning to the machine
	localparam logic [3:0] OP_UNKNOWN_LO = 4'd8;
	localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

	// Directed table row: either a size-limit write or one input beat
	typedef struct {
		bit             is_cfg;
		logic [PcW-1:0] limit;
		in_item_t       beat;
		bit             typed;
		out_item_t      want;
	} plan_row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [PcW-1:0] cfg_wdata = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	in_item_t       in_item = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	out_item_t      out_item;

	// Machine state as the bench sees it
	logic [31:0]    gpr [RegCount];
	logic [31:0]    dmem [MemDepth];
	bit             dmem_valid [MemDepth];
	logic [PcW-1:0] pc_model;
	bit             halted_model;
	logic [PcW-1:0] mem_limit;

	out_item_t      pending_results [$];
	out_item_t      front;
	int             mismatches = 0;
	bit             in_calm = 1'b0;
	bit             out_calm = 1'b0;

	toy_register_machine_step_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// One machine step: returns the result beat and updates the state
	function automatic out_item_t run_instruction(input in_item_t b);
		out_item_t      r;
		logic [PcW-1:0] nxt;
		logic [31:0]    wv;
		status_t        st;
		logic [1:0]     ia;
		logic [1:0]     ib;
		logic [1:0]     ic;
		ia = b.operand_a[1:0];
		ib = b.operand_b[1:0];
		ic = b.operand_c[1:0];
		st = ST_DONE;
		wv = '0;
		if (halted_model) begin
			st = ST_HALTED;
		end else if (b.command == CMD_PRELOAD) begin
			wv = b.preload_value;
			dmem[b.preload_address] = wv;
			dmem_valid[b.preload_address] = 1'b1;
		end else if (pc_model >= mem_limit) begin
			st = ST_RANGE;
		end else begin
			nxt = pc_model + 1'b1;
			case (b.opcode)
				OP_LOAD: begin
					wv = dmem[gpr[ib][7:0]];
					gpr[ia] = wv;
				end
				OP_STORE: begin
					wv = gpr[ib];
					dmem[b.operand_a] = wv;
					dmem_valid[b.operand_a] = 1'b1;
				end
				OP_ADD: begin
					wv = gpr[ia] + gpr[ib];
					gpr[ic] = wv;
				end
				OP_HALT: begin
					halted_model = 1'b1;
					st = ST_HALTED;
					nxt = pc_model;
				end
				OP_JUMP: nxt = {1'b0, b.operand_a};
				OP_JUMP_IF: nxt = (gpr[ia] == gpr[ib]) ? {1'b0, b.operand_c} : pc_model;
				OP_INC: begin
					wv = gpr[ia] + 32'd1;
					gpr[ia] = wv;
				end
				OP_M0_INC: begin
					wv = dmem[0] + 32'd1;
					gpr[ia] = wv;
				end
				default: st = ST_UNKNOWN;
			endcase
			pc_model = nxt;
		end
		r.status = st;
		r.program_counter = pc_model;
		r.written_value = wv;
		return r;
	endfunction

	// Beat builders; fields the command ignores get random content
	function automatic in_item_t pre(input logic [7:0] addr, input logic [31:0] val);
		in_item_t b;
		b.command = CMD_PRELOAD;
		b.opcode = 4'($urandom);
		b.operand_a = 8'($urandom);
		b.operand_b = 8'($urandom);
		b.operand_c = 8'($urandom);
		b.preload_address = addr;
		b.preload_value = val;
		return b;
	endfunction

	function automatic in_item_t exe(input logic [3:0] op, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		in_item_t it;
		it = pre(8'($urandom), $urandom);
		it.command = CMD_EXEC;
		it.opcode = op;
		it.operand_a = a;
		it.operand_b = b;
		it.operand_c = c;
		return it;
	endfunction

	function automatic out_item_t res(input status_t st, input logic [PcW-1:0] pc,
			input logic [31:0] wv);
		out_item_t r;
		r.status = st;
		r.program_counter = pc;
		r.written_value = wv;
		return r;
	endfunction

	// Random beat shaped by the current machine state: keeps programs running,
	// avoids reads of never-written words, no halt while it could execute
	function automatic in_item_t draw_beat();
		in_item_t b;
		bit       in_range;
		logic [7:0] rd_addr;
		b = exe(4'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
		case ($urandom_range(0, 9))
			0: b.preload_value = '0;
			1: b.preload_value = '1;
			default: ;
		endcase
		if ($urandom_range(0, 9) >= 8)
			b.opcode = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
		if ($urandom_range(0, 99) < 22)
			b.command = CMD_PRELOAD;
		in_range = !halted_model && (pc_model < mem_limit);

		if (b.command == CMD_EXEC && in_range) begin
			if (b.opcode == OP_HALT)
				b.opcode = OP_INC;
			if (b.opcode == OP_JUMP && $urandom_range(0, 5) != 0)
				b.operand_a = 8'($urandom_range(0, mem_limit - 1));
			if (b.opcode == OP_JUMP_IF) begin
				if ($urandom_range(0, 1) == 0)
					b.operand_b = {6'($urandom), b.operand_a[1:0]};
				if ($urandom_range(0, 5) != 0)
					b.operand_c = 8'($urandom_range(0, mem_limit - 1));
			end
			// loop back near the top of memory; pc 256 would lock the machine
			if ((pc_model == 9'd255 || (pc_model == mem_limit - 1'b1 &&
					$urandom_range(0, 3) != 0)) &&
					!(b.opcode inside {OP_JUMP, OP_JUMP_IF})) begin
				b.opcode = OP_JUMP;
				b.operand_a = 8'($urandom_range(0, mem_limit - 1));
			end
		end

		// a read of an unwritten word becomes a preload of that word
		if (b.command == CMD_EXEC && (b.opcode == OP_LOAD || b.opcode == OP_M0_INC)) begin
			rd_addr = (b.opcode == OP_LOAD) ? gpr[b.operand_b[1:0]][7:0] : 8'd0;
			if (!dmem_valid[rd_addr]) begin
				b.command = CMD_PRELOAD;
				b.preload_address = rd_addr;
			end
		end
		return b;
	endfunction

	// Drive one beat, wait for acceptance, record what must come back
	task automatic issue(input in_item_t beat, input bit typed, input out_item_t want);
		int        gap;
		out_item_t got;
		if ($urandom_range(0, 29) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = run_instruction(beat);
		pending_results.push_back(typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [PcW-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mem_limit = v;
	endtask

	// Receiver: random back-pressure per result beat
	initial begin
		int hold;
		forever begin
			if ($urandom_range(0, 29) == 0)
				out_calm = !out_calm;
			hold = out_calm ? 0 : $urandom_range(0, 7);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %p", $time,
					out_item);
				mismatches++;
			end else begin
				front = pending_results.pop_front();
				if (out_item.status !== front.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d", $time,
						front.status, out_item.status);
					mismatches++;
				end
				if (out_item.program_counter !== front.program_counter) begin
					$display("%0t: program_counter mismatch, expected %0d, actual %0d",
						$time, front.program_counter, out_item.program_counter);
					mismatches++;
				end
				if (out_item.written_value !== front.written_value) begin
					$display("%0t: written_value mismatch, expected %h, actual %h", $time,
						front.written_value, out_item.written_value);
					mismatches++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		plan_row_t      plan [$];
		logic [PcW-1:0] sizes [7];
		int             n_items;
		out_item_t      none;

		none = res(ST_DONE, '0, '0);
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem_valid[i]) dmem_valid[i] = 1'b0;
		pc_model = '0;
		halted_model = 1'b0;
		mem_limit = CfgReset;

		// extremes, every operation, wraps, index and address folding, out of range
		plan.push_back('{0, 0, pre(8'h00, 32'hFFFF_FFFF), 1, res(ST_DONE, 9'd0, 32'hFFFF_FFFF)});
		plan.push_back('{0, 0, pre(8'hFF, 32'h0), 1, res(ST_DONE, 9'd0, 32'h0)});
		plan.push_back('{0, 0, exe(OP_M0_INC, 8'h01, 8'h00, 8'h00), 1,
			res(ST_DONE, 9'd1, 32'h0)});
		plan.push_back('{0, 0, pre(8'h00, 32'd5), 1, res(ST_DONE, 9'd1, 32'd5)});
		plan.push_back('{0, 0, exe(OP_M0_INC, 8'h02, 8'h00, 8'h00), 1,
			res(ST_DONE, 9'd2, 32'd6)});
		plan.push_back('{0, 0, exe(OP_INC, 8'hFF, 8'h00, 8'h00), 1, res(ST_DONE, 9'd3, 32'd1)});
		plan.push_back('{0, 0, exe(OP_ADD, 8'h02, 8'h03, 8'hFC), 1, res(ST_DONE, 9'd4, 32'd7)});
		plan.push_back('{0, 0, exe(OP_STORE, 8'hFF, 8'h00, 8'h00), 1,
			res(ST_DONE, 9'd5, 32'd7)});
		plan.push_back('{0, 0, pre(8'h07, 32'hA5A5_A5A5), 1, res(ST_DONE, 9'd5, 32'hA5A5_A5A5)});
		plan.push_back('{0, 0, exe(OP_LOAD, 8'h01, 8'h00, 8'h00), 1,
			res(ST_DONE, 9'd6, 32'hA5A5_A5A5)});
		plan.push_back('{0, 0, exe(OP_UNKNOWN_HI, 8'h00, 8'h00, 8'h00), 1,
			res(ST_UNKNOWN, 9'd7, 32'h0)});
		plan.push_back('{0, 0, exe(OP_UNKNOWN_LO, 8'hFF, 8'hFF, 8'hFF), 1,
			res(ST_UNKNOWN, 9'd8, 32'h0)});
		plan.push_back('{0, 0, exe(OP_JUMP_IF, 8'h00, 8'h04, 8'h80), 1,
			res(ST_DONE, 9'd128, 32'h0)});
		plan.push_back('{0, 0, exe(OP_JUMP_IF, 8'h00, 8'h01, 8'h03), 1,
			res(ST_DONE, 9'd128, 32'h0)});
		plan.push_back('{0, 0, exe(OP_JUMP, 8'hFF, 8'h00, 8'h00), 1, res(ST_DONE, 9'd255, 32'h0)});
		plan.push_back('{0, 0, exe(OP_JUMP, 8'h00, 8'h00, 8'h00), 1, res(ST_DONE, 9'd0, 32'h0)});
		// smallest memory size: one step, then out of range
		plan.push_back('{1, 9'd1, pre(8'h00, 32'h0), 0, none});
		plan.push_back('{0, 0, exe(OP_INC, 8'h00, 8'h00, 8'h00), 1, res(ST_DONE, 9'd1, 32'd8)});
		plan.push_back('{0, 0, exe(OP_INC, 8'h00, 8'h00, 8'h00), 1, res(ST_RANGE, 9'd1, 32'h0)});
		plan.push_back('{0, 0, pre(8'hAA, 32'h5A5A_5A5A), 1, res(ST_DONE, 9'd1, 32'h5A5A_5A5A)});
		plan.push_back('{0, 0, exe(OP_HALT, 8'h00, 8'h00, 8'h00), 1, res(ST_RANGE, 9'd1, 32'h0)});
		plan.push_back('{0, 0, exe(OP_UNKNOWN_LO + 4'd1, 8'h00, 8'h00, 8'h00), 1,
			res(ST_RANGE, 9'd1, 32'h0)});
		plan.push_back('{1, CfgReset, pre(8'h00, 32'h0), 0, none});
		plan.push_back('{0, 0, exe(OP_ADD, 8'h01, 8'h01, 8'h02), 0, none});
		plan.push_back('{0, 0, pre(8'hA5, 32'h8000_0000), 1, res(ST_DONE, 9'd2, 32'h8000_0000)});
		plan.push_back('{0, 0, exe(OP_LOAD, 8'h03, 8'h01, 8'h00), 1,
			res(ST_DONE, 9'd3, 32'h8000_0000)});
		plan.push_back('{0, 0, exe(OP_JUMP, 8'h00, 8'h00, 8'h00), 1, res(ST_DONE, 9'd0, 32'h0)});

		// memory sizes of the random phases; the first keeps the current one
		sizes = '{CfgReset, 9'd1, 9'($urandom_range(3, 254)), 9'd2, 9'd255,
			9'($urandom_range(3, 254)), CfgReset};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_limit(plan[i].limit);
			else
				issue(plan[i].beat, plan[i].typed, plan[i].want);
		end

		// random programs, one phase per memory size
		foreach (sizes[p]) begin
			if (p != 0) begin
				// steer the counter into the next size while still executing
				if (pc_model < mem_limit)
					issue(exe(OP_JUMP, 8'($urandom_range(0, sizes[p] - 1)), 8'($urandom),
						8'($urandom)), 0, none);
				write_limit(sizes[p]);
			end
			n_items = $urandom_range(100, 130);
			repeat (n_items) issue(draw_beat(), 0, none);
		end

		// halt, then everything after it is ignored
		write_limit(CfgReset);
		issue(exe(OP_HALT, 8'($urandom), 8'($urandom), 8'($urandom)), 0, none);
		issue(pre(8'($urandom), $urandom), 0, none);
		issue(exe(OP_INC, 8'($urandom), 8'($urandom), 8'($urandom)), 0, none);
		issue(exe(OP_JUMP, 8'($urandom), 8'($urandom), 8'($urandom)), 0, none);
		issue(exe(OP_UNKNOWN_HI, 8'($urandom), 8'($urandom), 8'($urandom)), 0, none);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
